>>> rtl/multichannel_biquad_cascade_filter_macros.svh
// assertion helpers for the biquad cascade checker
`ifndef MULTICHANNEL_BIQUAD_CASCADE_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_CASCADE_FILTER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define BQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define BQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mbq_pkg.sv
package mbq_pkg;
    localparam int SECTIONS  = 4;
    localparam int CHANNELS  = 8;
    localparam int NREGS     = 8;
    localparam int COEF_W    = 20;
    localparam int FRAC      = 17;
    localparam int STATE_W   = 40;
    localparam int SAMPLE_W  = 24;
    localparam int CH_W      = 3;
    localparam int SEC_W     = 2;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 60;
    localparam int ADDR_W    = 5;
    localparam int DEPTH     = 32;
    localparam int PROD_W    = 62;
    localparam int ACC_W     = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL_Y,
        ST_SAT_Y,
        ST_MUL_Z,
        ST_WRITE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             load;
        logic             rd;
        logic             mul_y;
        logic             take_y;
        logic             mul_z;
        logic             wr;
        logic [SEC_W-1:0] sec;
    } t_cmd;

    function automatic logic signed [STATE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] s;
        r = acc + (ACC_W'(1) <<< (FRAC - 1));
        s = r >>> FRAC;
        if (s > ACC_W'(64'sh7F_FFFF_FFFF))
            return {1'b0, {(STATE_W-1){1'b1}}};
        else if (s < -ACC_W'(64'sh80_0000_0000))
            return {1'b1, {(STATE_W-1){1'b0}}};
        return s[STATE_W-1:0];
    endfunction
endpackage

>>> rtl/mbq_ram.sv
module mbq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mbq_ctrl.sv
module mbq_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [mbq_pkg::CH_W-1:0] i_channel,
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output mbq_pkg::t_cmd          o_cmd
);
    import mbq_pkg::*;

    t_state r_state, n_state;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic r_out_valid, n_out_valid;
    logic r_active, n_active;

    // next state
    always_comb begin
        n_state = r_state;
        n_sec = r_sec;
        n_active = r_active;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (!r_out_valid || i_out_ready)) begin
                    n_sec = '0;
                    n_active = (32'(i_channel) < CHANNELS);
                    n_state = n_active ? ST_READ : ST_OUT;
                end
            end
            ST_READ:  n_state = ST_MUL_Y;
            ST_MUL_Y: n_state = ST_SAT_Y;
            ST_SAT_Y: n_state = ST_MUL_Z;
            ST_MUL_Z: n_state = ST_WRITE;
            ST_WRITE: begin
                if (32'(r_sec) == SECTIONS - 1) begin
                    n_state = ST_OUT;
                end else begin
                    n_sec = r_sec + 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (r_state == ST_OUT) n_out_valid = 1'b1;
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        o_cmd.sec = r_sec;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                o_cmd.load = i_in_valid && o_in_ready;
            end
            ST_READ:  o_cmd.rd = 1'b1;
            ST_MUL_Y: o_cmd.mul_y = 1'b1;
            ST_SAT_Y: o_cmd.take_y = 1'b1;
            ST_MUL_Z: o_cmd.mul_z = 1'b1;
            ST_WRITE: o_cmd.wr = r_active;
            ST_OUT:   ;
            default:  ;
        endcase
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sec <= '0;
            r_out_valid <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sec <= n_sec;
            r_out_valid <= n_out_valid;
            r_active <= n_active;
        end
    end
endmodule

>>> rtl/mbq_dp.sv
module mbq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mbq_pkg::t_cmd                  i_cmd,
    input  logic signed [mbq_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [mbq_pkg::CH_W-1:0]       i_channel,
    input  logic                           i_cfg_we,
    input  logic [mbq_pkg::IDX_W-1:0]      i_cfg_idx,
    input  logic [mbq_pkg::CFG_W-1:0]      i_cfg_data,
    output logic signed [mbq_pkg::SAMPLE_W-1:0] o_sample,
    output logic [mbq_pkg::CH_W-1:0]       o_channel
);
    import mbq_pkg::*;

    logic [CFG_W-1:0] r_fw [SECTIONS];
    logic [STATE_W-1:0] r_fb [SECTIONS];
    logic signed [STATE_W-1:0] r_x;
    logic [CH_W-1:0] r_ch;
    logic signed [COEF_W-1:0] b0, b1, b2, a1, a2;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [PROD_W-1:0] r_q1, r_q2;
    logic signed [STATE_W-1:0] r_y;
    logic signed [STATE_W-1:0] z1, z2, n1, n2;
    logic [ADDR_W-1:0] addr;
    logic [DEPTH-1:0] r_valid;
    logic signed [ACC_W-1:0] acc_y, acc_1, acc_2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SECTIONS; s++) begin
                r_fw[s] <= CFG_W'(1 << FRAC);
                r_fb[s] <= '0;
            end
        end else if (i_cfg_we && !i_cfg_idx[0] && 32'(i_cfg_idx[IDX_W-1:1]) < SECTIONS) begin
            r_fw[i_cfg_idx[IDX_W-1:1]] <= i_cfg_data;
        end else if (i_cfg_we && i_cfg_idx[0] && 32'(i_cfg_idx[IDX_W-1:1]) < SECTIONS) begin
            r_fb[i_cfg_idx[IDX_W-1:1]] <= i_cfg_data[STATE_W-1:0];
        end
    end

    assign b0 = r_fw[i_cmd.sec][COEF_W-1:0];
    assign b1 = r_fw[i_cmd.sec][2*COEF_W-1:COEF_W];
    assign b2 = r_fw[i_cmd.sec][3*COEF_W-1:2*COEF_W];
    assign a1 = r_fb[i_cmd.sec][COEF_W-1:0];
    assign a2 = r_fb[i_cmd.sec][2*COEF_W-1:COEF_W];
    assign addr = {r_ch, i_cmd.sec};

    logic [STATE_W-1:0] rd1, rd2;
    mbq_ram #(.WIDTH(STATE_W), .DEPTH(DEPTH)) u_z1 (
        .i_clk(i_clk), .i_we(i_cmd.wr), .i_waddr(addr), .i_wdata(n1),
        .i_raddr(addr), .o_rdata(rd1)
    );
    mbq_ram #(.WIDTH(STATE_W), .DEPTH(DEPTH)) u_z2 (
        .i_clk(i_clk), .i_we(i_cmd.wr), .i_waddr(addr), .i_wdata(n2),
        .i_raddr(addr), .o_rdata(rd2)
    );

    // entries never written read as zero
    assign z1 = r_valid[addr] ? rd1 : '0;
    assign z2 = r_valid[addr] ? rd2 : '0;

    assign acc_y = ACC_W'(r_p0) + (ACC_W'(z1) <<< FRAC);
    assign acc_1 = ACC_W'(r_p1) - ACC_W'(r_q1) + (ACC_W'(z2) <<< FRAC);
    assign acc_2 = ACC_W'(r_p2) - ACC_W'(r_q2);
    assign n1 = round_sat(acc_1);
    assign n2 = round_sat(acc_2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr) begin
            r_valid[addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= STATE_W'(i_sample);
            r_ch <= i_channel;
        end
        if (i_cmd.mul_y) begin
            r_p0 <= PROD_W'(b0) * PROD_W'(r_x);
            r_p1 <= PROD_W'(b1) * PROD_W'(r_x);
            r_p2 <= PROD_W'(b2) * PROD_W'(r_x);
        end
        if (i_cmd.take_y) begin
            r_y <= round_sat(acc_y);
        end
        if (i_cmd.mul_z) begin
            r_q1 <= PROD_W'(a1) * PROD_W'(r_y);
            r_q2 <= PROD_W'(a2) * PROD_W'(r_y);
        end
        if (i_cmd.wr) begin
            r_x <= r_y;
        end
    end

    always_comb begin
        if (r_x > STATE_W'((1 << (SAMPLE_W - 1)) - 1))
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (r_x < -STATE_W'(1 << (SAMPLE_W - 1)))
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            o_sample = r_x[SAMPLE_W-1:0];
    end
    assign o_channel = r_ch;
endmodule

>>> rtl/multichannel_biquad_cascade_filter.sv
// channel    | delays kept        | items
// -----------+--------------------+--------------------------------------
// s_axis     | -                  | sample_in (23:0), channel_in (26:24)
// m_axis     | -                  | sample_out (23:0), channel_out (26:24)
// cfg write  | -                  | coefficient registers 0..7
// each item passes through the four sections in turn
// per section: delay ram read, forward products, y rounding, feedback products, write back
// channel numbers beyond the channel count skip the sections and pass through
// reset is synchronous active low, delay valid bits clear at once
// a new item is taken only once the held result leaves, at the latest in that same cycle
module multichannel_biquad_cascade_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_in, channel_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // sample_out, channel_out
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [59:0] i_cfg_data
);
    import mbq_pkg::*;

    t_cmd cmd;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic [CH_W-1:0] ch_q;
    logic [SAMPLE_W-1:0] r_out_s;
    logic [CH_W-1:0] r_out_c;

    mbq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_channel(s_axis_tdata[26:24]),
        .i_out_ready(m_axis_tready),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_cmd(cmd)
    );

    mbq_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_sample(s_axis_tdata[23:0]), .i_channel(s_axis_tdata[26:24]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_sample(sample_q), .o_channel(ch_q)
    );

    // output register, loaded unless a held result is stalled, so it keeps the value from the end of the item
    always_ff @(posedge i_clk) begin
        if (!m_axis_tvalid || m_axis_tready) begin
            r_out_s <= sample_q;
            r_out_c <= ch_q;
        end
    end

    assign m_axis_tdata = {5'b0, r_out_c, r_out_s};
endmodule

>>> rtl/mbq_checker.sv
`include "multichannel_biquad_cascade_filter_macros.svh"
module mbq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `BQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `BQ_ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[31:27] == 5'b0, "pad bits set")
    `BQ_ASSERT_NEXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "took two items")
endmodule

bind multichannel_biquad_cascade_filter mbq_checker u_chk (.*);

>>> dv/tb_multichannel_biquad_cascade_filter.sv
module tb_multichannel_biquad_cascade_filter;
    import mbq_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic [CH_W-1:0]            channel;
    } t_filtered;

    // register index names, forward/feedback pair per section
    typedef enum logic [IDX_W-1:0] {
        REG_SEC0_FWD, REG_SEC0_FB, REG_SEC1_FWD, REG_SEC1_FB,
        REG_SEC2_FWD, REG_SEC2_FB, REG_SEC3_FWD, REG_SEC3_FB
    } t_reg_idx;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [CFG_W-1:0] UNITY_FWD = 60'd131072;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sample_in (23:0), channel_in (26:24)
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // sample_out (23:0), channel_out (26:24)
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [59:0] i_cfg_data;

    multichannel_biquad_cascade_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // predictor copy of coefficients and per-channel delay lines
    logic [CFG_W-1:0]          coef_regs [NREGS];
    logic signed [STATE_W-1:0] z1_mem [CHANNELS][SECTIONS];
    logic signed [STATE_W-1:0] z2_mem [CHANNELS][SECTIONS];
    t_filtered                 filtered_q [$];

    int  n_errors;
    int  n_sent;
    int  n_checked;
    int  idle_cycles;
    bit  stall_on;     // random idling enabled on both sides

    function automatic logic signed [ACC_W-1:0] coef_of(logic [CFG_W-1:0] r, int k);
        logic [COEF_W-1:0] c;
        c = r[k*COEF_W +: COEF_W];
        return ACC_W'($signed(c));
    endfunction

    // half-up rounding by 2^17 then clamp to 40-bit state range
    function automatic logic signed [STATE_W-1:0] scale_clamp(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        s = (acc + 64'sd65536) >>> FRAC;
        if (s > 64'sh7F_FFFF_FFFF)
            return {1'b0, {(STATE_W-1){1'b1}}};
        if (s < -64'sh80_0000_0000)
            return {1'b1, {(STATE_W-1){1'b0}}};
        return s[STATE_W-1:0];
    endfunction

    function automatic logic [31:0] pack_in(logic signed [SAMPLE_W-1:0] smp,
                                            logic [CH_W-1:0] ch);
        return {5'd0, ch, smp};
    endfunction

    // run one item through the cascade model, updating delays
    function automatic t_filtered filter_sample(logic signed [SAMPLE_W-1:0] smp,
                                                logic [CH_W-1:0] ch);
        t_filtered               res;
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] b0, b1, b2, a1, a2;
        logic signed [ACC_W-1:0] z1, z2;
        x = ACC_W'(smp);
        if (ch < CHANNELS) begin
            for (int s = 0; s < SECTIONS; s++) begin
                b0 = coef_of(coef_regs[2*s], 0);
                b1 = coef_of(coef_regs[2*s], 1);
                b2 = coef_of(coef_regs[2*s], 2);
                a1 = coef_of(coef_regs[2*s+1], 0);
                a2 = coef_of(coef_regs[2*s+1], 1);
                z1 = ACC_W'(z1_mem[ch][s]);
                z2 = ACC_W'(z2_mem[ch][s]);
                y  = ACC_W'(scale_clamp(b0 * x + (z1 <<< FRAC)));
                z1_mem[ch][s] = scale_clamp(b1 * x - a1 * y + (z2 <<< FRAC));
                z2_mem[ch][s] = scale_clamp(b2 * x - a2 * y);
                x = y;
            end
        end
        if (x > 64'sd8388607)
            res.sample = 24'sh7FFFFF;
        else if (x < -64'sd8388608)
            res.sample = 24'sh800000;
        else
            res.sample = x[SAMPLE_W-1:0];
        res.channel = ch;
        return res;
    endfunction

    // tvalid stays high after the item; a random idle before the next item, or the drain, takes it down
    task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch);
        while (stall_on && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_in(smp, ch);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        filtered_q.insert(filtered_q.size(), filter_sample(smp, ch));
        n_sent++;
    endtask

    // coefficient write, only while nothing is in flight
    task automatic write_coef(t_reg_idx idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        coef_regs[idx] = val;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (filtered_q.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // coefficient in Q3.17 with a magnitude bound
    function automatic logic [COEF_W-1:0] rand_coef(int bound);
        return COEF_W'($urandom_range(2*bound) - bound);
    endfunction

    task automatic load_section(int s, logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                                logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                                logic [COEF_W-1:0] a2);
        write_coef(t_reg_idx'(2*s), {b2, b1, b0});
        write_coef(t_reg_idx'(2*s+1), {a2, a1});
    endtask

    // mild random stable-ish filter set per section
    task automatic load_random_cascade();
        for (int s = 0; s < SECTIONS; s++) begin
            load_section(s, rand_coef(90000), rand_coef(90000), rand_coef(90000),
                         rand_coef(60000), rand_coef(40000));
        end
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'sh7FFFFF;
            1:       return 24'sh800000;
            2:       return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // reset defaults are unity passthrough everywhere
    task automatic test_reset_passthrough();
        send_sample(24'sh7FFFFF, 3'd0);
        send_sample(24'sh800000, 3'd7);
        send_sample(24'sh000000, 3'd3);
        send_sample(24'sh000001, 3'd5);
        send_sample(24'shFFFFFF, 3'd1);
        send_sample(24'sh555555, 3'd2);
        send_sample(24'shAAAAAA, 3'd6);
        send_sample(24'sh123456, 3'd4);
        wait_drained();
    endtask

    // extreme coefficients: saturation of state and output
    task automatic test_extreme_coefs();
        load_section(0, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF);
        load_section(1, 20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000);
        load_section(2, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000);
        load_section(3, 20'h7FFFF, 20'h00000, 20'h00000, 20'h00000, 20'h00000);
        for (int i = 0; i < 12; i++)
            send_sample(i[0] ? 24'sh7FFFFF : 24'sh800000, CH_W'(i % 3));
        wait_drained();
        // all zero coefficients silence the cascade
        for (int s = 0; s < SECTIONS; s++)
            load_section(s, '0, '0, '0, '0, '0);
        send_sample(24'sh7FFFFF, 3'd0);
        send_sample(24'sh800000, 3'd1);
        wait_drained();
    endtask

    // random coefficient phases with random traffic
    task automatic test_random_traffic();
        for (int ph = 0; ph < 7; ph++) begin
            load_random_cascade();
            stall_on = (ph != 3);
            for (int i = 0; i < 150; i++)
                send_sample(rand_sample(), CH_W'($urandom_range(CHANNELS-1)));
            wait_drained();
        end
        stall_on = 1'b1;
        // back to reset values at the end
        for (int s = 0; s < SECTIONS; s++)
            load_section(s, UNITY_FWD[COEF_W-1:0], '0, '0, '0, '0);
        for (int i = 0; i < 10; i++)
            send_sample(rand_sample(), CH_W'($urandom_range(CHANNELS-1)));
        wait_drained();
    endtask

    // output side: random backpressure and the result checker
    always @(posedge i_clk) begin
        t_filtered exp_r;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(stall_on && $urandom_range(99) < 27);
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected item: tdata %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    exp_r = filtered_q.pop_front();
                    n_checked++;
                    if (m_axis_tdata[23:0] !== exp_r.sample) begin
                        $error("sample_out expected %h actual %h",
                               exp_r.sample, m_axis_tdata[23:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[26:24] !== exp_r.channel) begin
                        $error("channel_out expected %0d actual %0d",
                               exp_r.channel, m_axis_tdata[26:24]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d items outstanding", filtered_q.size());
            $display("multichannel_biquad_cascade_filter regression: fail");
            $finish;
        end
    end

    initial begin
        n_errors = 0; n_sent = 0; n_checked = 0;
        stall_on = 1'b1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        for (int r = 0; r < NREGS; r++)
            coef_regs[r] = (r % 2 == 0) ? UNITY_FWD : '0;
        for (int c = 0; c < CHANNELS; c++)
            for (int s = 0; s < SECTIONS; s++) begin
                z1_mem[c][s] = '0;
                z2_mem[c][s] = '0;
            end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_extreme_coefs();
        test_random_traffic();

        $display("covered %0d items, %0d results checked, over 11 coefficient sets",
                 n_sent, n_checked);
        $display("incl. saturating extremes, all channels, random stalls on both sides");
        if (n_errors == 0 && filtered_q.size() == 0)
            $display("multichannel_biquad_cascade_filter regression: pass");
        else
            $display("multichannel_biquad_cascade_filter regression: fail");
        $finish;
    end
endmodule
